FILE: hdl/assert_macros.svh
// Assertion macros for the card detect debouncer.
// Simulation builds get concurrent assertions; synthesis builds get nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CDD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: label");
`define CDD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: label");
`define CDD_ASSERT_RESET(label, clk, rst_n, cons) \
    label: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
        else $error("assertion failed: label");
`else
`define CDD_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define CDD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`define CDD_ASSERT_RESET(label, clk, rst_n, cons)
`endif
`endif

FILE: hdl/cdd_pkg.sv
// Shared types and constants for the card detect debouncer.
// No dependencies.
`timescale 1ns / 1ps

package cdd_pkg;

    localparam int COUNT_W = 8;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DATA_W = 8;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;
    localparam logic [COUNT_W-1:0] THRESHOLD_RESET = 8'd250;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_THRESHOLD = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_ACTIVE_LOW = 8'd1;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef enum logic [1:0] {
        ST_RELEASED = 2'd0,
        ST_DETECTED = 2'd1,
        ST_JUST_DET = 2'd2,
        ST_JUST_REL = 2'd3
    } status_t;

    typedef struct packed {
        logic [COUNT_W-1:0] threshold;
        logic               active_low;
    } cfg_t;

    typedef struct packed {
        logic in_full;
        logic advance;
    } pipe_state_t;

endpackage

FILE: hdl/cdd_cfg_regs.sv
// Configuration register file: detect threshold and pin polarity.
// Depends on cdd_pkg.
`timescale 1ns / 1ps

module cdd_cfg_regs
    import cdd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_IDX_THRESHOLD:  cfg_next.threshold  = cfg_data[COUNT_W-1:0];
                CFG_IDX_ACTIVE_LOW: cfg_next.active_low = cfg_data[0];
                default: ;  // drop writes to unknown registers
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.threshold  <= THRESHOLD_RESET;
            cfg_reg.active_low <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: hdl/cdd_engine.sv
// Input register, debounce count and presence status update, result register.
// Depends on cdd_pkg.
`timescale 1ns / 1ps

module cdd_engine
    import cdd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_command,
    input  logic        s_pin_level,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic        m_card_removed,
    output pipe_state_t pipe
);

    logic               in_valid_reg, in_valid_next;
    logic               in_cmd_reg;
    logic               in_pin_reg;
    logic               out_valid_reg, out_valid_next;
    status_t            out_status_reg;
    logic               out_removed_reg;
    logic [COUNT_W-1:0] count_reg, count_next;
    status_t            status_reg, status_next;
    status_t            shown;
    logic               removed;
    logic               advance;
    logic               active;
    logic [COUNT_W-1:0] count_inc;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    assign active    = in_pin_reg ^ cfg.active_low;
    assign count_inc = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;

    always_comb begin
        count_next  = count_reg;
        status_next = status_reg;
        removed     = 1'b0;
        if (in_cmd_reg == CMD_READ) begin
            if (status_reg == ST_JUST_DET) begin
                status_next = ST_DETECTED;
            end else if (status_reg == ST_JUST_REL) begin
                status_next = ST_RELEASED;
            end
        end else if (active) begin
            if (count_reg == cfg.threshold) begin
                // an unread release blocks detection; retry on the next tick
                if (status_reg != ST_JUST_REL) begin
                    status_next = ST_JUST_DET;
                    count_next  = count_inc;
                end
            end else begin
                count_next = count_inc;
            end
        end else begin
            removed = (count_reg != '0);
            if (status_reg == ST_DETECTED) begin
                status_next = ST_JUST_REL;
            end else if (status_reg != ST_JUST_REL) begin
                status_next = ST_RELEASED;
            end
            count_next = '0;
        end
        // a read shows the status before its update, a tick after
        shown = (in_cmd_reg == CMD_READ) ? status_reg : status_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            status_reg    <= ST_RELEASED;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                count_reg  <= count_next;
                status_reg <= status_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_cmd_reg <= s_command;
            in_pin_reg <= s_pin_level;
        end
        if (advance) begin
            out_status_reg  <= shown;
            out_removed_reg <= removed;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_status       = out_status_reg;
    assign m_card_removed = out_removed_reg;
    assign pipe.in_full   = in_valid_reg;
    assign pipe.advance   = advance;

endmodule

FILE: hdl/card_detect_debouncer.sv
// Top level of the card detect debouncer.
// Depends on cdd_pkg, cdd_cfg_regs, cdd_engine and assert_macros.svh.
//
// Usage:
//   Input channel (s_valid/s_ready): one beat is a tick with a pin sample
//   (s_command = 0) or a status read (s_command = 1).
//   Result channel (m_valid/m_ready): one beat per input beat, carrying the
//   presence status and the removal flag.
//   Config channel (cfg_valid/cfg_ready): index 0 sets the detect threshold,
//   index 1 the pin polarity; other indexes are ignored. Always ready; write
//   only while no beat is in flight.
//
// An input beat is held in the input register, then passes through the status
// update into the result register. Throughput is one beat per cycle while the
// receiver holds m_ready high, set by the count and status update.
// When the receiver stalls, the result register holds and the input register
// still takes one more beat; after that s_ready drops until m_ready returns.
// Reset clears the valid flags of both pipeline registers, the count and the
// status (released), and restores threshold 250 and active-high polarity.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module card_detect_debouncer
    import cdd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_command,
    input  logic                  s_pin_level,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [1:0]            m_status,
    output logic                  m_card_removed
);

    cfg_t        cfg;
    pipe_state_t pipe;

    cdd_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cdd_engine u_engine (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_pin_level    (s_pin_level),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_card_removed (m_card_removed),
        .pipe           (pipe)
    );

    `CDD_ASSERT_RESET(a_reset_empty, aclk, aresetn, !m_valid && s_ready)
    `CDD_ASSERT_NEXT(a_advance_fills_out, aclk, aresetn, pipe.advance, m_valid)
    `CDD_ASSERT_IMPL(a_full_stall_blocks, aclk, aresetn,
        m_valid && !m_ready && pipe.in_full, !s_ready)
    `CDD_ASSERT_IMPL(a_removed_status, aclk, aresetn, m_valid && m_card_removed,
        m_status == ST_RELEASED || m_status == ST_JUST_REL)

endmodule

FILE: tb/tb_card_detect_debouncer.sv
// Self-checking testbench for card_detect_debouncer: a directed table, then random
// phases over several threshold and polarity settings, checked beat by beat.
// Depends on cdd_pkg and the card_detect_debouncer RTL.
`timescale 1ns / 1ps

module tb_card_detect_debouncer;
    import cdd_pkg::*;

    typedef struct packed {
        status_t st;
        logic    removed;
    } report_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    // ROW_ITEM: a = command, b = pin level; ROW_CFG: a = register index, b = data
    typedef struct packed {
        row_kind_t kind;
        logic [7:0] a;
        logic [7:0] b;
        logic       typed;
        status_t    st;
        logic       rm;
    } dir_row_t;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOP   = 8'hFF;
    localparam int N_DIR = 27;
    localparam int N_PH  = 6;
    localparam int STEADY_PHASE = 3;

    logic                  aclk;
    logic                  aresetn     = 1'b0;
    logic                  cfg_valid   = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;
    logic                  s_valid     = 1'b0;
    logic                  s_ready;
    logic                  s_command   = CMD_TICK;
    logic                  s_pin_level = 1'b0;
    logic                  m_valid;
    logic                  m_ready     = 1'b0;
    logic [1:0]            m_status;
    logic                  m_card_removed;

    // predictor state and register copies
    logic [COUNT_W-1:0] det_cnt  = '0;
    status_t            presence = ST_RELEASED;
    logic [COUNT_W-1:0] thr_reg  = THRESHOLD_RESET;
    logic               pol_low  = 1'b0;

    report_t expected_reports [$];
    report_t head_report;
    int      mismatches = 0;
    bit      steady = 1'b0;

    dir_row_t dir_tab [0:N_DIR-1] = '{
        '{ROW_ITEM, CMD_READ, 8'd1, 1'b1, ST_RELEASED, 1'b0},
        '{ROW_ITEM, CMD_TICK, 8'd0, 1'b1, ST_RELEASED, 1'b0},
        '{ROW_CFG,  CFG_IDX_THRESHOLD, 8'd0, 1'b0, ST_RELEASED, 1'b0},
        // threshold zero: first active tick detects
        '{ROW_ITEM, CMD_TICK, 8'd1, 1'b1, ST_JUST_DET, 1'b0},
        '{ROW_ITEM, CMD_READ, 8'd0, 1'b1, ST_JUST_DET, 1'b0},
        '{ROW_ITEM, CMD_READ, 8'd1, 1'b1, ST_DETECTED, 1'b0},
        '{ROW_ITEM, CMD_TICK, 8'd0, 1'b1, ST_JUST_REL, 1'b1},
        // unread release blocks the detect
        '{ROW_ITEM, CMD_TICK, 8'd1, 1'b1, ST_JUST_REL, 1'b0},
        '{ROW_ITEM, CMD_READ, 8'd0, 1'b1, ST_JUST_REL, 1'b0},
        '{ROW_ITEM, CMD_TICK, 8'd1, 1'b0, ST_RELEASED, 1'b0},
        // unread detect dropped by an inactive tick
        '{ROW_ITEM, CMD_TICK, 8'd0, 1'b1, ST_RELEASED, 1'b1},
        '{ROW_CFG,  CFG_IDX_ACTIVE_LOW, 8'd1, 1'b0, ST_RELEASED, 1'b0},
        '{ROW_ITEM, CMD_TICK, 8'd0, 1'b0, ST_RELEASED, 1'b0},
        '{ROW_ITEM, CMD_TICK, 8'd1, 1'b0, ST_RELEASED, 1'b0},
        '{ROW_CFG,  CFG_IDX_THRESHOLD, 8'd2, 1'b0, ST_RELEASED, 1'b0},
        '{ROW_CFG,  CFG_IDX_ACTIVE_LOW, 8'd0, 1'b0, ST_RELEASED, 1'b0},
        '{ROW_ITEM, CMD_TICK, 8'd1, 1'b0, ST_RELEASED, 1'b0},
        '{ROW_ITEM, CMD_TICK, 8'd1, 1'b0, ST_RELEASED, 1'b0},
        '{ROW_ITEM, CMD_TICK, 8'd1, 1'b0, ST_RELEASED, 1'b0},
        '{ROW_ITEM, CMD_TICK, 8'd1, 1'b0, ST_RELEASED, 1'b0},
        '{ROW_ITEM, CMD_READ, 8'd0, 1'b0, ST_RELEASED, 1'b0},
        '{ROW_ITEM, CMD_TICK, 8'd0, 1'b0, ST_RELEASED, 1'b0},
        '{ROW_ITEM, CMD_TICK, 8'd0, 1'b0, ST_RELEASED, 1'b0},
        // unknown indexes must leave both registers alone
        '{ROW_CFG,  CFG_IDX_SPARE, 8'd0, 1'b0, ST_RELEASED, 1'b0},
        '{ROW_CFG,  CFG_IDX_TOP, 8'hFF, 1'b0, ST_RELEASED, 1'b0},
        '{ROW_ITEM, CMD_READ, 8'd0, 1'b0, ST_RELEASED, 1'b0},
        '{ROW_ITEM, CMD_READ, 8'd1, 1'b0, ST_RELEASED, 1'b0}
    };

    int ph_thr    [0:N_PH-1] = '{1, 0, 3, 7, 254, 255};
    int ph_low    [0:N_PH-1] = '{0, 1, 1, 0, 1, 0};
    int ph_budget [0:N_PH-1] = '{80, 60, 90, 90, 240, 240};

    card_detect_debouncer i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_pin_level    (s_pin_level),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_card_removed (m_card_removed)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #3_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // advance the presence state by one beat and return what the block should report
    function automatic report_t step_presence(input logic cmd, input logic pin);
        report_t r;
        r.removed = 1'b0;
        r.st = presence;
        if (cmd == CMD_READ) begin
            if (presence == ST_JUST_DET) begin
                presence = ST_DETECTED;
            end else if (presence == ST_JUST_REL) begin
                presence = ST_RELEASED;
            end
        end else if ((pin ^ pol_low) == 1'b1) begin
            if (det_cnt == thr_reg) begin
                // hold the count at the threshold while a release is unread
                if (presence != ST_JUST_REL) begin
                    presence = ST_JUST_DET;
                    if (det_cnt != COUNT_MAX) det_cnt = det_cnt + 1'b1;
                end
            end else if (det_cnt != COUNT_MAX) begin
                det_cnt = det_cnt + 1'b1;
            end
            r.st = presence;
        end else begin
            r.removed = (det_cnt != '0);
            if (presence == ST_DETECTED) begin
                presence = ST_JUST_REL;
            end else if (presence != ST_JUST_REL) begin
                presence = ST_RELEASED;
            end
            det_cnt = '0;
            r.st = presence;
        end
        return r;
    endfunction

    // entered and left at a falling edge
    task automatic send_beat(input logic cmd, input logic pin, input logic typed,
                             input report_t want);
        report_t got;
        while (!steady && $urandom_range(0, 99) < 13) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_command   <= cmd;
        s_pin_level <= pin;
        do @(posedge aclk); while (!s_ready);
        got = step_presence(cmd, pin);
        expected_reports.push_back(typed ? want : got);
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        s_valid <= 1'b0;
        while (expected_reports.size() != 0) @(negedge aclk);
        repeat (3) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == CFG_IDX_THRESHOLD) begin
            thr_reg = data;
        end else if (idx == CFG_IDX_ACTIVE_LOW) begin
            pol_low = data[0];
        end
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // bursts of active ticks around the threshold, with reads, releases and noise
    task automatic presence_bursts(input int budget);
        int   n;
        int   len;
        int   k;
        int   pick;
        bit   first;
        logic act;
        logic junk;
        n = 0;
        first = 1'b1;
        act = ~pol_low;
        while (n < budget) begin
            pick = $urandom_range(0, 99);
            if (first || pick < 55) begin
                if (first || $urandom_range(0, 99) < 60) begin
                    len = int'(thr_reg) + $urandom_range(1, 4);
                end else begin
                    len = $urandom_range(0, int'(thr_reg));
                end
                for (k = 0; k < len; k++) begin
                    pick = $urandom_range(0, 99);
                    junk = 1'($urandom_range(0, 1));
                    // open each phase with a clean run so the threshold is crossed
                    if (first) begin
                        send_beat(CMD_TICK, act, 1'b0, '0);
                    end else if (pick < 10) begin
                        send_beat(CMD_READ, junk, 1'b0, '0);
                    end else if (pick < 12) begin
                        send_beat(CMD_TICK, ~act, 1'b0, '0);
                    end else begin
                        send_beat(CMD_TICK, act, 1'b0, '0);
                    end
                end
            end else begin
                len = $urandom_range(1, 3);
                for (k = 0; k < len; k++) begin
                    junk = 1'($urandom_range(0, 1));
                    if (pick < 78) begin
                        send_beat(CMD_TICK, ~act, 1'b0, '0);
                    end else begin
                        send_beat(CMD_READ, junk, 1'b0, '0);
                    end
                end
            end
            n += len;
            first = 1'b0;
        end
    endtask

    always @(negedge aclk) begin
        m_ready <= steady || ($urandom_range(0, 99) >= 13);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: status %0d removed %0d",
                             m_status, m_card_removed);
            end else begin
                head_report = expected_reports.pop_front();
                if (m_status !== head_report.st || m_card_removed !== head_report.removed) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: status exp %0d got %0d, removed exp %0d got %0d",
                                 head_report.st, m_status, head_report.removed,
                                 m_card_removed);
                end
            end
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < N_DIR; i++) begin
            if (dir_tab[i].kind == ROW_CFG) begin
                write_reg(dir_tab[i].a, dir_tab[i].b);
            end else begin
                send_beat(dir_tab[i].a[0], dir_tab[i].b[0], dir_tab[i].typed,
                          '{dir_tab[i].st, dir_tab[i].rm});
            end
        end

        for (int p = 0; p < N_PH; p++) begin
            write_reg(CFG_IDX_THRESHOLD, 8'(ph_thr[p]));
            write_reg(CFG_IDX_ACTIVE_LOW, 8'(ph_low[p]));
            steady = (p == STEADY_PHASE);
            presence_bursts(ph_budget[p]);
        end
        steady = 1'b0;

        s_valid <= 1'b0;
        while (expected_reports.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
